FILE: rtl/core/swm_pkg.sv
// Shared constants of the sliding-window median core.
`default_nettype none

package swm_pkg;

	localparam int DEF_SAMPLE_BITS = 8;
	localparam int DEF_MAX_WINDOW = 64;

	localparam int CFG_BITS = 7;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd3;

endpackage

`default_nettype wire

FILE: rtl/core/swm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module swm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/sliding_window_median_core.sv
// Top level of the sliding-window median core with its delay line and count tree.
//
//   Channel   Direction  Signals                          Word
//   s_axis    in         tvalid, tready, tdata            sample
//   m_axis    out        tvalid, tready, tdata            lower median
//   cfg       in         cfg_we, cfg_wdata                window size
//
// Each accepted sample walks the distinct count-tree nodes on its insertion path and, once the
// window is full, its removal path (1 to 2 * SAMPLE_BITS + 1 nodes), then searches the tree bit
// by bit for the median once the window is full; the next sample is accepted only after that.
// The count-tree RAM makes one read and one write a cycle.
// After reset and after every window size write, a clearing pass zeroes the count tree,
// during which s_axis_tready stays low.
// A result waiting on m_axis does not block the next sample from being accepted, but that
// sample then waits in the output state until the waiting word is taken.
`default_nettype none

module sliding_window_median_core import swm_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_BITS-1:0] cfg_wdata,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [DW-1:0]       s_axis_tdata,   // sample
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic      [DW-1:0]       m_axis_tdata    // median
);

	localparam int SB = SAMPLE_BITS;
	localparam int BIN = 1 << SAMPLE_BITS;
	localparam int PW = SAMPLE_BITS + 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int KW = $clog2(SAMPLE_BITS);
	localparam logic [SB-1:0] FIRST_ADDR = SB'(BIN / 2 - 1);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_OLD,
		S_UPD,
		S_SEL0,
		S_SEL,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		D_NONE,
		D_INC,
		D_DEC
	} delta_t;

	state_t              state_q;
	logic [CFG_BITS-1:0] cfg_q;
	logic [CW-1:0]       fill_q;
	logic [SW-1:0]       write_slot_q;
	logic [SB-1:0]       clr_q;
	logic                a_act_q;
	logic                b_act_q;
	logic                pend_q;
	logic                full_q;
	logic [KW-1:0]       k_q;
	logic                out_v_q;

	logic [SB-1:0]       s_q;
	logic [SW-1:0]       slot_q;
	logic [PW-1:0]       pa_q;
	logic [PW-1:0]       pb_q;
	logic [SB-1:0]       wa_q;
	delta_t              dl_q;
	logic [SB-1:0]       pos_q;
	logic [CW-1:0]       left_q;
	logic [SB-1:0]       res_q;
	logic [SB-1:0]       out_d_q;

	logic [CW-1:0]       weff;
	logic [SW-1:0]       slot_eff;
	logic [CW-1:0]       slot_inc;
	logic [SW-1:0]       slot_next;
	logic                rem;
	logic [CW-1:0]       fill_inc;
	logic [PW:0]         pa_ext;
	logic [PW:0]         pb_ext;
	logic [PW:0]         pa_adv;
	logic [PW:0]         pb_adv;
	logic                a_stay;
	logic                b_stay;
	logic [PW-1:0]       cur;
	logic                ina;
	logic                inb;
	delta_t              dnext;
	logic [SB-1:0]       cur_addr;
	logic [SB-1:0]       stride;
	logic [SB-1:0]       sel_next;
	logic                sel_take;
	logic [SB-1:0]       sel_pos;
	logic [CW-1:0]       sel_left;
	logic [SB-1:0]       sel_addr;
	logic [CW-1:0]       target;

	logic                ct_we;
	logic [SB-1:0]       ct_waddr;
	logic [CW-1:0]       ct_wdata;
	logic [SB-1:0]       ct_raddr;
	logic [CW-1:0]       ct_rdata;
	logic [CW-1:0]       upd_wdata;

	logic                ws_we;
	logic [SB-1:0]       ws_rdata;

	always_comb begin
		if (cfg_q == '0) begin
			weff = CW'(1);
		end else if (int'(cfg_q) > MAX_WINDOW) begin
			weff = CW'(MAX_WINDOW);
		end else begin
			weff = CW'(cfg_q);
		end
	end

	assign slot_eff = (CW'(write_slot_q) >= weff) ? '0 : write_slot_q;
	assign slot_inc = CW'(slot_q) + CW'(1);
	assign slot_next = (slot_inc >= weff) ? '0 : SW'(slot_inc);
	assign rem = (fill_q >= weff);
	assign fill_inc = fill_q + CW'(1);

	assign pa_ext = {1'b0, pa_q};
	assign pb_ext = {1'b0, pb_q};
	assign pa_adv = pa_ext + (pa_ext & (~pa_ext + (PW + 1)'(1)));
	assign pb_adv = pb_ext + (pb_ext & (~pb_ext + (PW + 1)'(1)));
	assign a_stay = (pa_adv <= (PW + 1)'(BIN));
	assign b_stay = (pb_adv <= (PW + 1)'(BIN));

	always_comb begin
		if (a_act_q && b_act_q) begin
			cur = (pa_q < pb_q) ? pa_q : pb_q;
		end else if (a_act_q) begin
			cur = pa_q;
		end else begin
			cur = pb_q;
		end
	end

	assign ina = a_act_q && (pa_q == cur);
	assign inb = b_act_q && (pb_q == cur);
	assign cur_addr = SB'(cur - PW'(1));

	always_comb begin
		priority if (ina && inb) begin
			dnext = D_NONE;
		end else if (ina) begin
			dnext = D_DEC;
		end else if (inb) begin
			dnext = D_INC;
		end else begin
			dnext = D_NONE;
		end
	end

	always_comb begin
		unique case (dl_q)
			D_INC: upd_wdata = ct_rdata + CW'(1);
			D_DEC: upd_wdata = ct_rdata - CW'(1);
			default: upd_wdata = ct_rdata;
		endcase
	end

	assign stride = SB'(1) << k_q;
	assign sel_next = pos_q | stride;
	assign sel_take = (ct_rdata < left_q);
	assign sel_pos = sel_take ? sel_next : pos_q;
	assign sel_left = sel_take ? (left_q - ct_rdata) : left_q;
	assign sel_addr = (sel_pos | (stride >> 1)) - SB'(1);
	assign target = CW'(({1'b0, weff} + (CW + 1)'(1)) >> 1);

	always_comb begin
		ct_we = 1'b0;
		ct_waddr = wa_q;
		ct_wdata = upd_wdata;
		ct_raddr = cur_addr;
		unique case (state_q)
			S_CLR: begin
				ct_we = 1'b1;
				ct_waddr = clr_q;
				ct_wdata = '0;
			end
			S_UPD: begin
				ct_we = pend_q;
			end
			S_SEL0: begin
				ct_raddr = FIRST_ADDR;
			end
			S_SEL: begin
				ct_raddr = sel_addr;
			end
			default: begin
			end
		endcase
	end

	assign ws_we = (state_q == S_OLD);

	swm_ram #(
		.WIDTH(CW),
		.DEPTH(BIN)
	) u_count_ram (
		.clk  (clk),
		.we   (ct_we),
		.waddr(ct_waddr),
		.wdata(ct_wdata),
		.raddr(ct_raddr),
		.rdata(ct_rdata)
	);

	swm_ram #(
		.WIDTH(SB),
		.DEPTH(MAX_WINDOW)
	) u_window_ram (
		.clk  (clk),
		.we   (ws_we),
		.waddr(slot_q),
		.wdata(s_q),
		.raddr(slot_eff),
		.rdata(ws_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cfg_q <= CFG_RESET;
			fill_q <= '0;
			write_slot_q <= '0;
			clr_q <= '0;
			a_act_q <= 1'b0;
			b_act_q <= 1'b0;
			pend_q <= 1'b0;
			full_q <= 1'b0;
			k_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready && (cfg_we || state_q != S_OUT)) begin
				out_v_q <= 1'b0;
			end
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
				fill_q <= '0;
				write_slot_q <= '0;
				clr_q <= '0;
				pend_q <= 1'b0;
				state_q <= S_CLR;
			end else begin
				unique case (state_q)
					S_CLR: begin
						clr_q <= clr_q + SB'(1);
						if (clr_q == '1) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (s_axis_tvalid) begin
							state_q <= S_OLD;
						end
					end
					S_OLD: begin
						a_act_q <= rem;
						b_act_q <= 1'b1;
						if (!rem) begin
							fill_q <= fill_inc;
						end
						full_q <= rem || (fill_inc >= weff);
						write_slot_q <= slot_next;
						pend_q <= 1'b0;
						state_q <= S_UPD;
					end
					S_UPD: begin
						if (a_act_q || b_act_q) begin
							pend_q <= 1'b1;
							if (ina) begin
								a_act_q <= a_stay;
							end
							if (inb) begin
								b_act_q <= b_stay;
							end
						end else begin
							pend_q <= 1'b0;
							state_q <= full_q ? S_SEL0 : S_IDLE;
						end
					end
					S_SEL0: begin
						k_q <= KW'(SAMPLE_BITS - 1);
						state_q <= S_SEL;
					end
					S_SEL: begin
						if (k_q == '0) begin
							state_q <= S_OUT;
						end else begin
							k_q <= k_q - KW'(1);
						end
					end
					S_OUT: begin
						if (!out_v_q || m_axis_tready) begin
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_CLR;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				s_q <= s_axis_tdata[SB-1:0];
				slot_q <= slot_eff;
			end
			S_OLD: begin
				pa_q <= {1'b0, ws_rdata} + PW'(1);
				pb_q <= {1'b0, s_q} + PW'(1);
			end
			S_UPD: begin
				wa_q <= cur_addr;
				dl_q <= dnext;
				if (ina) begin
					pa_q <= PW'(pa_adv);
				end
				if (inb) begin
					pb_q <= PW'(pb_adv);
				end
			end
			S_SEL0: begin
				pos_q <= '0;
				left_q <= target;
			end
			S_SEL: begin
				pos_q <= sel_pos;
				left_q <= sel_left;
				res_q <= sel_pos;
			end
			S_OUT: begin
				if (!out_v_q || m_axis_tready) begin
					out_d_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = DW'(out_d_q);

	// The window never holds more samples than its size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= weff)
		else $error("fill count exceeds window size");

	// The next delay-line slot always lies inside the window.
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		write_slot_q < CW'(weff))
		else $error("write slot outside window");

	// During the update walk, no tree read targets the node written back in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && pend_q && (a_act_q || b_act_q)) |-> (ct_raddr != wa_q))
		else $error("count tree read and write collide");

	// A result word appears only after the output state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_OUT))
		else $error("result word without a finished search");

endmodule

`default_nettype wire

FILE: test/median_checker.sv
// Checker that predicts the lower median of each full window and compares it with the core output.
module median_checker
	import swm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // sample
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [7:0]          m_axis_tdata,   // median
	output int                  errors,
	output int                  pending_medians
);

	localparam int BINS = 1 << DEF_SAMPLE_BITS;
	localparam int EXP_DEPTH = 16;

	logic [7:0]          history [DEF_MAX_WINDOW];
	int unsigned         bin_count [BINS];
	int unsigned         fill;
	int unsigned         slot;
	logic [CFG_BITS-1:0] window_reg;
	logic [7:0]          expected_medians [EXP_DEPTH];
	int                  exp_head;
	int                  exp_tail;
	int                  exp_count;
	int                  error_total;

	initial begin
		errors = 0;
		pending_medians = 0;
		error_total = 0;
		exp_head = 0;
		exp_tail = 0;
		exp_count = 0;
	end

	function automatic int unsigned window_len(input logic [CFG_BITS-1:0] reg_value);
		int unsigned w;
		w = int'(reg_value);
		if (w == 0)
			w = 1;
		if (w > DEF_MAX_WINDOW)
			w = DEF_MAX_WINDOW;
		return w;
	endfunction

	function automatic logic [7:0] lower_median(input int unsigned w);
		int unsigned target;
		int unsigned acc;
		target = (w + 1) >> 1;
		acc = 0;
		for (int v = 0; v < BINS; v++) begin
			acc += bin_count[v];
			if (acc >= target)
				return v[7:0];
		end
		return '0;
	endfunction

	task automatic clear_window();
		for (int i = 0; i < DEF_MAX_WINDOW; i++)
			history[i] = '0;
		for (int v = 0; v < BINS; v++)
			bin_count[v] = 0;
		fill = 0;
		slot = 0;
	endtask

	task automatic take_sample(input logic [7:0] s);
		int unsigned w;
		w = window_len(window_reg);
		if (slot >= w)
			slot = 0;
		if (fill >= w)
			bin_count[history[slot]]--;
		else
			fill++;
		history[slot] = s;
		bin_count[s]++;
		slot++;
		if (slot >= w)
			slot = 0;
		if (fill >= w) begin
			expected_medians[exp_tail] = lower_median(w);
			exp_tail = (exp_tail + 1) % EXP_DEPTH;
			exp_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			window_reg = CFG_RESET;
			clear_window();
			exp_head = 0;
			exp_tail = 0;
			exp_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (exp_count == 0) begin
					$display("%0t unexpected word: expected none, actual median %0d",
						$time, m_axis_tdata);
					error_total++;
				end else begin
					want = expected_medians[exp_head];
					exp_head = (exp_head + 1) % EXP_DEPTH;
					exp_count--;
					if (m_axis_tdata !== want) begin
						$display("%0t median mismatch: expected %0d, actual %0d",
							$time, want, m_axis_tdata);
						error_total++;
					end
				end
			end
			if (cfg_we) begin
				window_reg = cfg_wdata;
				clear_window();
			end
			if (s_axis_tvalid && s_axis_tready)
				take_sample(s_axis_tdata);
		end
		errors <= error_total;
		pending_medians <= exp_count;
	end

endmodule

FILE: test/tb_top.sv
// Testbench top that drives samples and window sizes into the median core and reports the verdict.
module tb_top;
	import swm_pkg::*;

	localparam int LIMIT = 400000;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES = 600;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;   // sample
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [7:0]          m_axis_tdata;        // median

	int   errors;
	int   pending_medians;
	int   cycle_count = 0;
	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	logic [7:0] corner_samples [12] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE,
		8'h00, 8'h00, 8'hFF, 8'hFF, 8'h55, 8'hAA};

	sliding_window_median_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	median_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.errors          (errors),
		.pending_medians (pending_medians)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("FAIL");
		$finish;
	end

	// The receiver stalls once for a long stretch so that the core backs up into its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(99) >= 6);
			end
		end
	end

	task automatic send_sample(input logic [7:0] value);
		if (!quiet && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic set_window(input logic [CFG_BITS-1:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_medians == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_sample(input int mode, input logic [7:0] center);
		logic [7:0] value;
		case (mode)
			0: begin
				value = 8'($urandom_range(255));
			end
			1: begin
				value = 8'($urandom_range(6));
				value = center + value - 8'd3;
			end
			default: begin
				case ($urandom_range(2))
					0: value = 8'h00;
					1: value = 8'hFF;
					default: value = center;
				endcase
			end
		endcase
		return value;
	endfunction

	initial begin
		int                  total;
		int                  phase_idx;
		int                  n;
		int                  mode;
		logic [CFG_BITS-1:0] win;
		logic [7:0]          center;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (corner_samples[i])
			send_sample(corner_samples[i]);
		set_window(7'd1);
		send_sample(8'h00);
		send_sample(8'hFF);
		send_sample(8'hA5);
		set_window(7'd0);
		send_sample(8'hFF);
		send_sample(8'h00);
		send_sample(8'h5A);
		// A window that never fills is discarded by the next size write.
		set_window(7'd6);
		send_sample(8'h10);
		send_sample(8'h20);
		send_sample(8'h30);
		set_window(7'd3);
		send_sample(8'hFF);
		send_sample(8'h00);
		send_sample(8'h80);
		send_sample(8'h80);

		total = 0;
		phase_idx = 0;
		while (total < 1000) begin
			case (phase_idx % 8)
				0: win = 7'd64;
				1: win = 7'd1;
				2: win = 7'd127;
				3: win = 7'd0;
				4: win = 7'd65;
				5: win = 7'd2;
				default: win = 7'($urandom_range(127, 0));
			endcase
			n = (phase_idx == 2) ? 200 : $urandom_range(120, 40);
			quiet = (phase_idx == 2);
			set_window(win);
			hold_req = (phase_idx == 5);
			mode = $urandom_range(2);
			center = 8'($urandom_range(255));
			repeat (n)
				send_sample(pick_sample(mode, center));
			s_axis_tvalid <= 1'b0;
			total += n;
			phase_idx++;
		end
		quiet = 1'b0;

		@(posedge clk);
		wait (pending_medians == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
